// ===== rtl/les_pkg.sv =====
package les_pkg;

  // Field widths
  localparam int FLOOR_W   = 5;
  localparam int REQ_W     = 6;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 8;

  // Sizing
  localparam int FLOOR_SLOTS    = 32;
  localparam int QUEUE_DEPTH    = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int CMD_FIFO_DEPTH = 2;

  localparam logic [FLOOR_W-1:0] MAX_FLOOR     = 5'd16;
  localparam logic [FLOOR_W-1:0] FLOORS_RESET  = 5'd16;
  localparam logic [FLOOR_W-1:0] GROUND_FLOOR  = 5'd1;

  // Input op codes
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_W-1:0] OP_SERVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_EMERG   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HERE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ARRIVED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;

  // Command kinds handed from front to back
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_REQ   = 2'd0;
  localparam kind_t KIND_SERVE = 2'd1;
  localparam kind_t KIND_EMERG = 2'd2;

  typedef struct packed {
    kind_t            kind;
    logic             in_range;
    logic [REQ_W-1:0] floor;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FLOOR_W-1:0]  floor;
    logic                last;
  } result_t;

endpackage

// ===== rtl/les_front.sv =====
module les_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [les_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [les_pkg::OP_W-1:0]        s_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [les_pkg::FLOOR_W-1:0]     cfg_data,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output les_pkg::cmd_t                   cmd
);
  import les_pkg::*;

  logic [FLOOR_W-1:0] floors_in_use;
  logic [FLOOR_W-1:0] limit;
  logic [REQ_W-1:0]   req_floor;
  logic               known;
  cmd_t               cmd_next;

  // Take register writes at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      floors_in_use <= FLOORS_RESET;
    end else if (cfg_valid) begin
      floors_in_use <= cfg_data;
    end
  end

  // Classify the incoming word
  assign req_floor = s_tdata[REQ_W-1:0];
  assign limit     = (floors_in_use < MAX_FLOOR) ? floors_in_use : MAX_FLOOR;

  always_comb begin
    known             = 1'b1;
    cmd_next.kind     = KIND_REQ;
    cmd_next.floor    = req_floor;
    cmd_next.in_range = (req_floor != '0) && (req_floor <= {1'b0, limit});
    case (s_tuser)
      OP_REQUEST: cmd_next.kind = KIND_REQ;
      OP_SERVE:   cmd_next.kind = KIND_SERVE;
      OP_EMERG:   cmd_next.kind = KIND_EMERG;
      default:    known = 1'b0;
    endcase
  end

  // Hold one classified command; drop undefined ops here
  assign s_tready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid && known;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== rtl/les_fifo.sv =====
module les_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  les_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output les_pkg::cmd_t pop_cmd
);
  import les_pkg::*;

  localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t             slots [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(CMD_FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/les_back.sv =====
module les_back #(
  parameter int QueueDepth = les_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  les_pkg::cmd_t    cmd,
  output logic             res_valid,
  input  logic             res_ready,
  output les_pkg::result_t res
);
  import les_pkg::*;

  localparam int CNT_W = $clog2(QueueDepth + 1);
  localparam int ARR_W = $clog2(MAX_RESULTS);
  localparam logic [FLOOR_SLOTS-1:0] ONES = '1;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_SERVE = 1'b1;

  // Lowest set bit of a floor mask, as a floor number
  function automatic logic [FLOOR_W-1:0] low_index(input logic [FLOOR_SLOTS-1:0] v);
    logic [FLOOR_SLOTS-1:0] iso;
    logic [FLOOR_W-1:0]     idx;
    iso = v & (~v + 1'b1);
    idx = '0;
    for (int i = 0; i < FLOOR_SLOTS; i++) begin
      idx = idx | ({FLOOR_W{iso[i]}} & FLOOR_W'(i));
    end
    return idx;
  endfunction

  // Highest set bit, through a bit reversal
  function automatic logic [FLOOR_W-1:0] high_index(input logic [FLOOR_SLOTS-1:0] v);
    logic [FLOOR_SLOTS-1:0] r;
    for (int i = 0; i < FLOOR_SLOTS; i++) begin
      r[i] = v[FLOOR_SLOTS-1-i];
    end
    return FLOOR_W'(FLOOR_SLOTS - 1) - low_index(r);
  endfunction

  logic                   state;
  logic [FLOOR_SLOTS-1:0] stops;
  logic [CNT_W-1:0]       stop_count;
  logic [FLOOR_W-1:0]     car_floor;
  logic                   going_down;
  logic [ARR_W-1:0]       arr_cnt;

  logic                   out_free;
  logic                   res_load;
  logic [FLOOR_SLOTS-1:0] up_mask;
  logic [FLOOR_SLOTS-1:0] dn_mask;
  logic                   up_found;
  logic                   dn_found;
  logic [FLOOR_W-1:0]     up_idx;
  logic [FLOOR_W-1:0]     dn_idx;
  logic [FLOOR_W-1:0]     next_stop;
  logic                   going_down_next;
  logic [FLOOR_SLOTS-1:0] stops_next;
  logic                   last_arr;
  logic [FLOOR_W-1:0]     req_floor;
  logic [STATUS_W-1:0]    req_status;

  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (state == S_IDLE) && out_free;

  // Find the nearest stop each way
  assign up_mask  = stops & ((ONES << car_floor) << 1);
  assign dn_mask  = stops & ~(ONES << car_floor);
  assign up_found = |up_mask;
  assign dn_found = |dn_mask;
  assign up_idx   = low_index(up_mask);
  assign dn_idx   = high_index(dn_mask);

  // Pick the next stop under the LOOK rule
  always_comb begin
    next_stop       = car_floor;
    going_down_next = going_down;
    if (stops[car_floor]) begin
      next_stop = car_floor;
    end else if (going_down) begin
      if (dn_found) begin
        next_stop = dn_idx;
      end else begin
        next_stop       = up_idx;
        going_down_next = 1'b0;
      end
    end else begin
      if (up_found) begin
        next_stop = up_idx;
      end else begin
        next_stop       = dn_idx;
        going_down_next = 1'b1;
      end
    end
    stops_next            = stops;
    stops_next[next_stop] = 1'b0;
  end

  assign last_arr = (stop_count == CNT_W'(1)) || (arr_cnt == ARR_W'(MAX_RESULTS - 1));

  // Check a request in priority order
  assign req_floor = cmd.floor[FLOOR_W-1:0];

  always_comb begin
    if (cmd.floor == {1'b0, car_floor}) begin
      req_status = ST_HERE;
    end else if (!cmd.in_range) begin
      req_status = ST_INVALID;
    end else if (stops[req_floor]) begin
      req_status = ST_QUEUED;
    end else if (stop_count >= CNT_W'(QueueDepth)) begin
      req_status = ST_FULL;
    end else begin
      req_status = ST_ACCEPTED;
    end
  end

  // Flag the cycles that load a result word
  always_comb begin
    case (state)
      S_IDLE: begin
        res_load = cmd_valid && cmd_ready &&
                   ((cmd.kind == KIND_REQ) ||
                    ((cmd.kind == KIND_SERVE) && (stop_count == '0)));
      end
      S_SERVE: begin
        res_load = out_free;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Execute commands and load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      stops      <= '0;
      stop_count <= '0;
      car_floor  <= GROUND_FLOOR;
      going_down <= 1'b0;
      arr_cnt    <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            case (cmd.kind)
              KIND_REQ: begin
                res.status <= req_status;
                res.floor  <= req_floor;
                res.last   <= 1'b1;
                if (req_status == ST_ACCEPTED) begin
                  stops[req_floor] <= 1'b1;
                  stop_count       <= stop_count + 1'b1;
                end
              end
              KIND_SERVE: begin
                if (stop_count == '0) begin
                  res.status <= ST_EMPTY;
                  res.floor  <= car_floor;
                  res.last   <= 1'b1;
                end else begin
                  state   <= S_SERVE;
                  arr_cnt <= '0;
                end
              end
              KIND_EMERG: begin
                car_floor <= GROUND_FLOOR;
              end
              default: begin
              end
            endcase
          end
        end
        S_SERVE: begin
          if (out_free) begin
            res.status <= ST_ARRIVED;
            res.floor  <= next_stop;
            res.last   <= last_arr;
            car_floor  <= next_stop;
            going_down <= going_down_next;
            stops      <= stops_next;
            stop_count <= stop_count - 1'b1;
            arr_cnt    <= arr_cnt + 1'b1;
            if (last_arr) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/look_elevator_scheduler.sv =====
// Channel  Dir  Signals                        Fields (lowest bit up)
// s        in   s_tvalid s_tready s_tdata      tdata: floor[5:0]; tuser: op[1:0]
//               s_tuser
// m        out  m_tvalid m_tready m_tdata      tdata: floor_res[4:0]; tuser: status[2:0];
//               m_tuser m_tlast                tlast: last
// cfg      in   cfg_valid cfg_ready cfg_data   data: floors_in_use[4:0]
//
// A request or emergency is executed in the idle state; a serve enters the serve state
// and makes its arrivals there (up to 16), each one paced by the m side.
// Input words pass a classify register and a two-entry command queue before the
// executor, which registers each result word; a serve dispatches before its first arrival.
// rst is synchronous: empty stop set, car on floor 1, heading up, 16 floors.
// A stalled m side holds the executor; the front keeps filling the queue.
module look_elevator_scheduler #(
  parameter int QUEUE_DEPTH = les_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [les_pkg::S_TDATA_W-1:0]   s_tdata,   // floor[5:0], zero above
  input  logic [les_pkg::OP_W-1:0]        s_tuser,   // op[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [les_pkg::M_TDATA_W-1:0]   m_tdata,   // floor_res[4:0], zero above
  output logic [les_pkg::STATUS_W-1:0]    m_tuser,   // status[2:0]
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [les_pkg::FLOOR_W-1:0]     cfg_data
);
  import les_pkg::*;

  logic    front_valid;
  logic    front_ready;
  cmd_t    front_cmd;
  logic    queue_valid;
  logic    queue_ready;
  cmd_t    queue_cmd;
  result_t res;

  les_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  les_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_cmd    (queue_cmd)
  );

  les_back #(
    .QueueDepth (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Pack the result word
  assign m_tdata = {{(M_TDATA_W - FLOOR_W){1'b0}}, res.floor};
  assign m_tuser = res.status;
  assign m_tlast = res.last;

endmodule

// ===== sim/look_elevator_scheduler_checker.sv =====
module look_elevator_scheduler_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [les_pkg::S_TDATA_W-1:0] s_tdata,   // floor[5:0], zero above
  input  logic [les_pkg::OP_W-1:0]      s_tuser,   // op[1:0]
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [les_pkg::M_TDATA_W-1:0] m_tdata,   // floor_res[4:0], zero above
  input  logic [les_pkg::STATUS_W-1:0]  m_tuser,   // status[2:0]
  input  logic                          m_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [les_pkg::FLOOR_W-1:0]   cfg_data,
  output int                            reports_pending,
  output int                            fail_count,
  output int                            reports_checked,
  output int                            arrivals_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import les_pkg::*;

  // Car model: floor limit, position, heading and the queued stops
  logic [FLOOR_W-1:0] floors_limit;
  logic [FLOOR_W-1:0] car_at;
  logic               heading_down;
  logic [FLOOR_W-1:0] stop_set [QUEUE_DEPTH];
  int                 stop_total;
  result_t            reports_due [$];
  result_t            want;

  function automatic bit floor_queued(input logic [FLOOR_W-1:0] f);
    int i;
    for (i = 0; i < stop_total; i++)
      if (stop_set[i] == f) return 1'b1;
    return 1'b0;
  endfunction

  // Nearest stop strictly ahead of the car in its heading; zero if none
  function automatic logic [FLOOR_W-1:0] nearest_ahead();
    int                 i;
    logic [FLOOR_W-1:0] best;
    bit                 found;
    bit                 ahead;
    best  = '0;
    found = 1'b0;
    for (i = 0; i < stop_total; i++) begin
      ahead = heading_down ? (stop_set[i] < car_at) : (stop_set[i] > car_at);
      if (ahead && (!found || (heading_down ? (stop_set[i] > best) : (stop_set[i] < best)))) begin
        best  = stop_set[i];
        found = 1'b1;
      end
    end
    return best;
  endfunction

  // Remove one stop and close the gap, keeping arrival order
  task automatic drop_floor(input logic [FLOOR_W-1:0] f);
    int i;
    int j;
    for (i = 0; i < stop_total; i++) begin
      if (stop_set[i] == f) begin
        for (j = i; j + 1 < stop_total; j++)
          stop_set[j] = stop_set[j + 1];
        stop_total--;
        return;
      end
    end
  endtask

  // Advance the car model by one input word and queue the words it must produce
  task automatic apply_car_word(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] fl);
    logic [FLOOR_W-1:0]  limit;
    logic [FLOOR_W-1:0]  next_floor;
    logic [STATUS_W-1:0] st;
    result_t             word;
    bit                  have_word;
    int                  k;
    limit = (floors_limit < MAX_FLOOR) ? floors_limit : MAX_FLOOR;
    case (op)
      OP_REQUEST: begin
        if (fl == {1'b0, car_at})
          st = ST_HERE;
        else if (fl < 1 || fl > {1'b0, limit})
          st = ST_INVALID;
        else if (floor_queued(fl[FLOOR_W-1:0]))
          st = ST_QUEUED;
        else if (stop_total >= QUEUE_DEPTH)
          st = ST_FULL;
        else begin
          stop_set[stop_total] = fl[FLOOR_W-1:0];
          stop_total++;
          st = ST_ACCEPTED;
        end
        word.status = st;
        word.floor  = fl[FLOOR_W-1:0];
        word.last   = 1'b1;
        reports_due.push_back(word);
      end
      OP_SERVE: begin
        if (stop_total == 0) begin
          word.status = ST_EMPTY;
          word.floor  = car_at;
          word.last   = 1'b1;
          reports_due.push_back(word);
        end else begin
          have_word = 1'b0;
          k = 0;
          while (stop_total > 0 && k < MAX_RESULTS) begin
            // a stop at the car floor goes first, without turning the car
            if (floor_queued(car_at))
              next_floor = car_at;
            else begin
              next_floor = nearest_ahead();
              if (next_floor == '0) begin
                heading_down = ~heading_down;
                next_floor = nearest_ahead();
              end
            end
            if (next_floor == '0) break;
            car_at = next_floor;
            drop_floor(next_floor);
            if (have_word) reports_due.push_back(word);
            word.status = ST_ARRIVED;
            word.floor  = next_floor;
            word.last   = 1'b0;
            have_word = 1'b1;
            k++;
          end
          if (have_word) begin
            word.last = 1'b1;
            reports_due.push_back(word);
          end
        end
      end
      OP_EMERG: car_at = GROUND_FLOOR;
      default: ;
    endcase
  endtask

  // Watch all three channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      floors_limit = FLOORS_RESET;
      car_at       = GROUND_FLOOR;
      heading_down = 1'b0;
      stop_total   = 0;
      reports_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        floors_limit = cfg_data;
      // compare each result word with the oldest expectation
      if (m_tvalid && m_tready) begin
        reports_checked++;
        if (reports_due.size() == 0) begin
          fail_count++;
          $display("%0t: expected no word, got status %0d floor_res %0d last %0d", $time,
                   m_tuser, m_tdata, m_tlast);
        end else begin
          want = reports_due.pop_front();
          if (want.status == ST_ARRIVED) arrivals_checked++;
          if (m_tuser !== want.status || m_tlast !== want.last ||
              m_tdata !== {{(M_TDATA_W-FLOOR_W){1'b0}}, want.floor}) begin
            fail_count++;
            $display("%0t: expected status %0d floor_res %0d last %0d, got %0d %0d %0d",
                     $time, want.status, want.floor, want.last, m_tuser, m_tdata, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready)
        apply_car_word(s_tuser, s_tdata[REQ_W-1:0]);
    end
    reports_pending = reports_due.size();
  end

endmodule

// ===== sim/look_elevator_scheduler_tb.sv =====
module look_elevator_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import les_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;   // undefined op, dropped by the block
  localparam int RANDOM_ITEMS  = 460;
  localparam int CFG_SPAN      = 50;
  localparam int SETTLE_CYCLES = 30;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // floor[5:0], zero above
  logic [OP_W-1:0]      s_tuser = '0;   // op[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // floor_res[4:0], zero above
  logic [STATUS_W-1:0]  m_tuser;        // status[2:0]
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [FLOOR_W-1:0]   cfg_data = '0;

  int reports_pending;
  int fail_count;
  int reports_checked;
  int arrivals_checked;

  int send_idle_pct = 19;
  int recv_idle_pct = 65;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int words_sent    = 0;
  int cfg_writes    = 0;

  logic [FLOOR_W-1:0] cfg_plan [10] = '{5'd31, 5'd2, 5'd0, 5'd16, 5'd1,
                                        5'd11, 5'd5, 5'd16, 5'd24, 5'd8};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  look_elevator_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  look_elevator_scheduler_checker watch (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .m_tlast          (m_tlast),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .reports_pending  (reports_pending),
    .fail_count       (fail_count),
    .reports_checked  (reports_checked),
    .arrivals_checked (arrivals_checked)
  );

  // Drive the result-side ready: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = $urandom_range(400, 150);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one word, with random gaps ahead of it, and wait for its handshake
  task automatic send_word(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] fl);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(S_TDATA_W-REQ_W){1'b0}}, fl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op != OP_NONE) words_sent++;
  endtask

  // Stop offering until every expected word is back, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_floor_limit(input logic [FLOOR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int               directed_sent;
    int               done;
    int               next_cfg_at;
    int               episode;
    int               kind;
    int               n;
    int               i;
    int               j;
    int               tmp;
    int               p;
    int               order [16];
    logic [REQ_W-1:0] fl;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset limit of 16, car on floor 1 heading up
    send_word(OP_SERVE, 6'd0);       // empty stop list
    send_word(OP_REQUEST, 6'd1);     // car already there
    send_word(OP_REQUEST, 6'd0);     // below range
    send_word(OP_REQUEST, 6'd63);    // top of the field
    send_word(OP_REQUEST, 6'd17);    // just above the limit
    send_word(OP_REQUEST, 6'd16);
    send_word(OP_REQUEST, 6'd5);
    send_word(OP_REQUEST, 6'd5);     // duplicate
    send_word(OP_REQUEST, 6'd3);
    send_word(OP_REQUEST, 6'd12);
    send_word(OP_SERVE, 6'd40);      // sweep up to 16
    send_word(OP_REQUEST, 6'd9);
    send_word(OP_REQUEST, 6'd2);
    send_word(OP_SERVE, 6'd0);       // nothing above, turn down
    send_word(OP_REQUEST, 6'd1);
    send_word(OP_REQUEST, 6'd7);
    send_word(OP_EMERG, 6'd21);      // car lands on a queued floor
    send_word(OP_NONE, 6'd42);
    send_word(OP_SERVE, 6'd0);       // stop at the car floor first, then turn up
    send_word(OP_REQUEST, 6'd32);    // wraps to floor 0 in the result
    send_word(OP_REQUEST, 6'd33);
    send_word(OP_EMERG, 6'd0);
    send_word(OP_SERVE, 6'd63);
    directed_sent = words_sent;

    // Random episodes, a new floor limit every CFG_SPAN words
    next_cfg_at = 0;
    episode = 0;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done >= next_cfg_at) begin
        settle();
        write_floor_limit(cfg_writes < 10 ? cfg_plan[cfg_writes]
                                          : FLOOR_W'($urandom_range(31)));
        next_cfg_at += CFG_SPAN;
        hold_requests++;
      end
      if (done < RANDOM_ITEMS / 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 65;
      end else if (done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      episode++;
      kind = (episode % 25 == 7) ? 10 : $urandom_range(9);
      case (kind)
        6, 9: send_word(OP_SERVE, REQ_W'($urandom_range(63)));
        7: send_word(OP_EMERG, REQ_W'($urandom_range(63)));
        8: begin
          // noise: any op with any floor bits
          send_word(OP_W'($urandom_range(3)), REQ_W'($urandom_range(63)));
        end
        10: begin
          // fill every floor, drop to ground, refill, then sweep them all
          for (i = 0; i < 16; i++) order[i] = i + 1;
          for (i = 15; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          for (i = 0; i < 16; i++) send_word(OP_REQUEST, REQ_W'(order[i]));
          send_word(OP_EMERG, 6'd0);
          for (i = 15; i >= 0; i--) send_word(OP_REQUEST, REQ_W'(order[i]));
          send_word(OP_SERVE, 6'd0);
        end
        default: begin
          // burst of requests, mostly in range, then usually a serve
          n = $urandom_range(8, 1);
          for (i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < 70)
              fl = REQ_W'($urandom_range(16, 1));
            else if (p < 90)
              fl = REQ_W'($urandom_range(20));
            else
              fl = REQ_W'($urandom_range(63));
            send_word(OP_REQUEST, fl);
          end
          if ($urandom_range(2) != 0) send_word(OP_SERVE, REQ_W'($urandom_range(63)));
        end
      endcase
      done = words_sent - directed_sent;
    end

    settle();
    $display("run covered %0d words over %0d floor-limit settings, with %0d long output stalls",
             words_sent, cfg_writes + 1, hold_requests);
    $display("checked %0d result words (%0d arrivals), %0d mismatches",
             reports_checked, arrivals_checked, fail_count);
    if (fail_count == 0 && reports_pending == 0)
      $display("look_elevator_scheduler_tb: clean");
    else
      $display("look_elevator_scheduler_tb: errors");
    $finish;
  end

  // Hard stop well past the slowest passing run
  initial begin
    #8_000_000;
    $display("timeout with %0d words still expected", reports_pending);
    $display("look_elevator_scheduler_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/les_pkg.sv
rtl/les_front.sv
rtl/les_fifo.sv
rtl/les_back.sv
rtl/look_elevator_scheduler.sv
sim/look_elevator_scheduler_checker.sv
sim/look_elevator_scheduler_tb.sv
